### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the estimator checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define HVE_ASSERT_DIS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hve assertion failed");

// property checked at every clock edge, reset included
`define HVE_ASSERT_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("hve assertion failed");

`endif

### hdl/hve_pkg.sv
// ----------------------------------------------------------------------------
// hve_pkg
// widths, constants, register codes and shared types of the estimator
// ----------------------------------------------------------------------------
package hve_pkg;

   localparam int TIME_W     = 32;
   localparam int HEAD_W     = 9;
   localparam int ACCEL_W    = 13;
   localparam int RANGE_W    = 16;
   localparam int SPEED_W    = 23;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int DEADBAND_W = 12;
   localparam int DECAY_W    = 9;
   localparam int STOP_W     = 16;
   localparam int PERIOD_W   = 20;
   localparam int TIMEOUT_W  = 16;
   localparam int LIMIT_W    = 16;
   // (timeout_ms + 1) * 1000 fits in 26 bits
   localparam int STILL_US_W = 26;

   localparam int DEG_FULL  = 360;
   localparam int DEG_HALF  = 180;
   localparam int US_PER_MS = 1000;

   localparam int SPEED_MAX = 4194303;
   localparam int SPEED_MIN = -4194304;

   localparam logic [RANGE_W-1:0] NO_DETECT = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEL_DEADBAND,
      CSR_DECAY_NUMERATOR,
      CSR_STOP_THRESHOLD,
      CSR_SAMPLE_PERIOD,
      CSR_STILL_TIMEOUT,
      CSR_STILL_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic [DEADBAND_W-1:0] deadband;
      logic [DECAY_W-1:0]    decay;
      logic [STOP_W-1:0]     stop;
      logic [PERIOD_W-1:0]   period;
      logic [STILL_US_W-1:0] still_us;
      logic [LIMIT_W-1:0]    still_limit;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]         time_us;
      logic [HEAD_W-1:0]         heading_raw_deg;
      logic                      reset_button;
      logic signed [ACCEL_W-1:0] accel_x;
      logic [RANGE_W-1:0]        right_range_speed;
      logic [RANGE_W-1:0]        left_range_speed;
   } req_item_type;

endpackage

### hdl/hve_if.sv
// ----------------------------------------------------------------------------
// hve_req_if / hve_rsp_if
// valid/ready channels carrying estimator items and results
// ----------------------------------------------------------------------------
interface hve_req_if import hve_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [TIME_W-1:0]         time_us;
   logic [HEAD_W-1:0]         heading_raw_deg;
   logic                      reset_button;
   logic signed [ACCEL_W-1:0] accel_x;
   logic [RANGE_W-1:0]        right_range_speed;
   logic [RANGE_W-1:0]        left_range_speed;

   modport source (
      output valid, time_us, heading_raw_deg, reset_button, accel_x,
             right_range_speed, left_range_speed,
      input  ready
   );
   modport sink (
      input  valid, time_us, heading_raw_deg, reset_button, accel_x,
             right_range_speed, left_range_speed,
      output ready
   );
endinterface

interface hve_rsp_if import hve_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [HEAD_W-1:0]  heading_deg;
   logic signed [SPEED_W-1:0] speed_x;

   modport source (output valid, heading_deg, speed_x, input ready);
   modport sink   (input valid, heading_deg, speed_x, output ready);
endinterface

### hdl/hve_heading.sv
// ----------------------------------------------------------------------------
// hve_heading
// heading offset store and relative heading wrap to -179..180
// ----------------------------------------------------------------------------
module hve_heading import hve_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [HEAD_W-1:0]        heading_raw,
   input  logic                     button,
   output logic signed [HEAD_W-1:0] heading
);

   localparam int DW = HEAD_W + 2;
   localparam logic signed [DW-1:0] FULL     = DW'(DEG_FULL);
   localparam logic signed [DW-1:0] TWO_FULL = DW'(2 * DEG_FULL);
   localparam logic signed [DW-1:0] HALF     = DW'(DEG_HALF);

   logic [HEAD_W-1:0]    offset_ff, offset_in;
   logic [HEAD_W-1:0]    offset_eff;
   logic signed [DW-1:0] diff, diff_mod, rel;

   always_comb begin
      offset_eff = button ? heading_raw : offset_ff;
      diff = $signed({2'b00, heading_raw}) - $signed({2'b00, offset_eff});
      // true modulo 360 of a difference within -511..511
      if (diff < -FULL) begin
         diff_mod = diff + TWO_FULL;
      end else if (diff < 0) begin
         diff_mod = diff + FULL;
      end else if (diff >= FULL) begin
         diff_mod = diff - FULL;
      end else begin
         diff_mod = diff;
      end
      rel       = (diff_mod > HALF) ? diff_mod - FULL : diff_mod;
      heading   = rel[HEAD_W-1:0];
      offset_in = (advance && button) ? heading_raw : offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

### hdl/hve_speed.sv
// ----------------------------------------------------------------------------
// hve_speed
// x speed integration, decay, stop clear and ultrasonic stillness zeroing
// ----------------------------------------------------------------------------
module hve_speed import hve_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  cfg_type                   cfg,
   input  logic [TIME_W-1:0]         now,
   input  logic signed [ACCEL_W-1:0] accel,
   input  logic [RANGE_W-1:0]        right_speed,
   input  logic [RANGE_W-1:0]        left_speed,
   output logic signed [SPEED_W-1:0] speed
);

   localparam int PW = ACCEL_W + 1;            // accel pair sum
   localparam int SW = SPEED_W + 1;            // speed plus step
   localparam int MW = SW + DECAY_W + 1;       // product
   localparam int QW = MW - 8;                 // product over 256
   localparam logic signed [QW-1:0] Q_MAX = QW'(SPEED_MAX);
   localparam logic signed [QW-1:0] Q_MIN = QW'(SPEED_MIN);

   logic                      started_ff, started_in;
   logic [TIME_W-1:0]         last_time_ff, last_time_in;
   logic                      accel_seen_ff, accel_seen_in;
   logic signed [ACCEL_W-1:0] last_accel_ff, last_accel_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic                      still_flag_ff, still_flag_in;
   logic [TIME_W-1:0]         still_start_ff, still_start_in;

   logic [TIME_W-1:0]         elapsed, still_elapsed, start_eff;
   logic                      do_step, is_still, expired;
   logic signed [PW-1:0]      accel_ext, mag;
   logic signed [ACCEL_W-1:0] accel_db, prev_accel;
   logic signed [PW-1:0]      pair;
   logic signed [SW-1:0]      sum;
   logic signed [MW-1:0]      prod;
   logic signed [QW-1:0]      quot;
   logic signed [SPEED_W-1:0] sat, stepped, step_speed;
   logic signed [SW-1:0]      sat_ext, sat_mag;

   always_comb begin
      // period check against the last step, or against now on the first item
      elapsed = now - (started_ff ? last_time_ff : now);
      do_step = elapsed >= TIME_W'(cfg.period);

      accel_ext  = PW'(accel);
      mag        = (accel_ext < 0) ? -accel_ext : accel_ext;
      accel_db   = (mag < $signed(PW'(cfg.deadband))) ? '0 : accel;
      prev_accel = accel_seen_ff ? last_accel_ff : accel;

      pair = PW'(accel_db) + PW'(prev_accel);
      sum  = SW'(speed_ff) + (SW'(pair) <<< 7);
      prod = MW'(sum) * $signed(MW'(cfg.decay));

      // divide by 256 rounding toward zero
      quot = prod[MW-1:8];
      if (prod[MW-1] && (prod[7:0] != '0)) begin
         quot = quot + QW'(1);
      end

      if (quot > Q_MAX) begin
         sat = SPEED_W'(SPEED_MAX);
      end else if (quot < Q_MIN) begin
         sat = SPEED_W'(SPEED_MIN);
      end else begin
         sat = quot[SPEED_W-1:0];
      end

      sat_ext = SW'(sat);
      sat_mag = (sat_ext < 0) ? -sat_ext : sat_ext;
      stepped = sat;
      if ((accel_db == '0) && (sat_mag < $signed(SW'(cfg.stop)))) begin
         stepped = '0;
      end
      step_speed = do_step ? stepped : speed_ff;

      is_still = (right_speed != NO_DETECT) && (left_speed != NO_DETECT) &&
                 (right_speed <= cfg.still_limit) && (left_speed <= cfg.still_limit);
      start_eff     = still_flag_ff ? still_start_ff : now;
      still_elapsed = now - start_eff;
      expired       = still_elapsed >= TIME_W'(cfg.still_us);

      speed = (is_still && expired) ? '0 : step_speed;

      started_in     = started_ff | advance;
      last_time_in   = (advance && (do_step || !started_ff)) ? now : last_time_ff;
      accel_seen_in  = accel_seen_ff | (advance && do_step);
      last_accel_in  = (advance && do_step) ? accel_db : last_accel_ff;
      speed_in       = advance ? speed : speed_ff;
      still_flag_in  = advance ? is_still : still_flag_ff;
      still_start_in = (advance && is_still && !still_flag_ff) ? now : still_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         last_time_ff   <= '0;
         accel_seen_ff  <= 1'b0;
         last_accel_ff  <= '0;
         speed_ff       <= '0;
         still_flag_ff  <= 1'b0;
         still_start_ff <= '0;
      end else begin
         started_ff     <= started_in;
         last_time_ff   <= last_time_in;
         accel_seen_ff  <= accel_seen_in;
         last_accel_ff  <= last_accel_in;
         speed_ff       <= speed_in;
         still_flag_ff  <= still_flag_in;
         still_start_ff <= still_start_in;
      end
   end

endmodule

### hdl/heading_and_velocity_estimator_core.sv
// ----------------------------------------------------------------------------
// heading_and_velocity_estimator_core
// relative heading and x speed estimate from heading, accel and ultrasonic items
// ----------------------------------------------------------------------------
// Takes one item per clock while results drain, and returns exactly one result
// per item, in order. An accepted item lands in an input register; once the
// result slot is free or draining, the heading and speed logic (one 24x10
// multiply for the decay, a saturate and a few compares) updates the state and
// loads the result register, from which the result is offered on rsp_ch.
// Throughput is one item per cycle while rsp_ch takes results.
// The result register frees the input side: a new item is taken while a result
// waits, and only a held result together with a full input register stalls
// req_ch. Registers are written through csr_we / csr_index / csr_wdata; the
// user must write them only while no item is in flight, as the block does not
// enforce it; an unknown index is ignored. The still timeout is kept internally
// in microseconds, (timeout_ms + 1) * 1000, so the timeout test is a plain
// compare. No clearing pass is needed after reset.
module heading_and_velocity_estimator_core import hve_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hve_req_if.sink               req_ch,
   hve_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam cfg_type CFG_RESET = '{
      deadband:    DEADBAND_W'(5),
      decay:       DECAY_W'(205),
      stop:        STOP_W'(256),
      period:      PERIOD_W'(10000),
      still_us:    STILL_US_W'((1500 + 1) * US_PER_MS),
      still_limit: LIMIT_W'(1)
   };

   cfg_type      cfg_ff, cfg_in;
   req_item_type stage_ff, stage_in;
   logic         stage_valid_ff, stage_valid_in;
   logic         out_valid_ff, out_valid_in;
   logic signed [HEAD_W-1:0]  out_heading_ff, out_heading_in;
   logic signed [SPEED_W-1:0] out_speed_ff, out_speed_in;

   logic                      accept, advance;
   logic signed [HEAD_W-1:0]  heading;
   logic signed [SPEED_W-1:0] speed;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ACCEL_DEADBAND:  cfg_in.deadband    = csr_wdata[DEADBAND_W-1:0];
            CSR_DECAY_NUMERATOR: cfg_in.decay       = csr_wdata[DECAY_W-1:0];
            CSR_STOP_THRESHOLD:  cfg_in.stop        = csr_wdata[STOP_W-1:0];
            CSR_SAMPLE_PERIOD:   cfg_in.period      = csr_wdata[PERIOD_W-1:0];
            CSR_STILL_TIMEOUT: begin
               // first elapsed time whose whole ms exceed the timeout
               cfg_in.still_us = (STILL_US_W'(csr_wdata[TIMEOUT_W-1:0]) + STILL_US_W'(1))
                                 * STILL_US_W'(US_PER_MS);
            end
            CSR_STILL_LIMIT:     cfg_in.still_limit = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the compute stage moves on when the result slot is free or drains
   always_comb begin
      advance      = stage_valid_ff && (!out_valid_ff || rsp_ch.ready);
      req_ch.ready = !stage_valid_ff || advance;
      accept       = req_ch.valid && req_ch.ready;

      stage_valid_in = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
      stage_in.time_us           = req_ch.time_us;
      stage_in.heading_raw_deg   = req_ch.heading_raw_deg;
      stage_in.reset_button      = req_ch.reset_button;
      stage_in.accel_x           = req_ch.accel_x;
      stage_in.right_range_speed = req_ch.right_range_speed;
      stage_in.left_range_speed  = req_ch.left_range_speed;

      out_valid_in   = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      out_heading_in = heading;
      out_speed_in   = speed;
   end

   // heading relative to the stored zero
   hve_heading u_heading (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .heading_raw (stage_ff.heading_raw_deg),
      .button      (stage_ff.reset_button),
      .heading     (heading)
   );

   // integration, decay and stillness zeroing of the x speed
   hve_speed u_speed (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cfg         (cfg_ff),
      .now         (stage_ff.time_us),
      .accel       (stage_ff.accel_x),
      .right_speed (stage_ff.right_range_speed),
      .left_speed  (stage_ff.left_range_speed),
      .speed       (speed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= CFG_RESET;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
      if (advance) begin
         out_heading_ff <= out_heading_in;
         out_speed_ff   <= out_speed_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.heading_deg = out_heading_ff;
   assign rsp_ch.speed_x     = out_speed_ff;

endmodule

### hdl/hve_checker.sv
// ----------------------------------------------------------------------------
// hve_checker
// port level checks of the estimator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hve_checker import hve_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [HEAD_W-1:0] rsp_heading
);

   // no result right after reset
   `HVE_ASSERT_ALL(a_reset_empty, clock, reset |=> !rsp_valid)

   // a held result stays offered
   `HVE_ASSERT_DIS(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // an accepted item followed by rsp_ready reaches the output through the input and result registers
   `HVE_ASSERT_DIS(a_latency, clock, reset, (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)

   // an offered heading is wrapped into -179..180
   `HVE_ASSERT_DIS(a_heading_range, clock, reset, rsp_valid |-> (rsp_heading >= -9'sd179) && (rsp_heading <= 9'sd180))

endmodule

bind heading_and_velocity_estimator_core hve_checker u_hve_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_heading (rsp_ch.heading_deg)
);
